### hdl/nkes_pkg.sv
// nkes_pkg: shared types and constants for the nearest-entity selector
// holds command/result word layouts, config register indexes and operation codes
// no dependencies
`default_nettype none

package nkes_pkg;

	localparam int COORD_W     = 16;
	localparam int ID_W        = 11;
	localparam int KEY_W       = 36;
	localparam int CNT_W       = 9;
	localparam int SLOT_W      = 8;
	localparam int OP_W        = 2;
	localparam int ABS_W       = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int MAX_ENTRIES_DEF = 256;

	localparam logic [CNT_W-1:0] CAPACITY_RST = 9'd64;

	// operation codes
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_OFFER  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Y = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Z = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic [ID_W-1:0]           entity_id;
		logic signed [COORD_W-1:0] box_min_x;
		logic signed [COORD_W-1:0] box_min_y;
		logic signed [COORD_W-1:0] box_min_z;
		logic signed [COORD_W-1:0] box_max_x;
		logic signed [COORD_W-1:0] box_max_y;
		logic signed [COORD_W-1:0] box_max_z;
		logic [SLOT_W-1:0]         slot;
	} cmd_t;

	typedef struct packed {
		logic             kept;
		logic             evicted_valid;
		logic [ID_W-1:0]  evicted_id;
		logic [CNT_W-1:0] entry_count;
		logic             slot_valid;
		logic [ID_W-1:0]  slot_id;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} viewer_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} entry_t;

endpackage

`default_nettype wire

### hdl/nkes_key_unit.sv
// nkes_key_unit: distance key of one offered box, one axis at a time
// one abs-difference step and one shared 17x17 square-accumulate step per axis
// depends on nkes_pkg
`default_nettype none

module nkes_key_unit
	import nkes_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire viewer_t          viewer,
	input  wire cmd_t             cmd,
	output logic                  done,
	output logic [KEY_W-1:0]      key
);

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	logic                run_q;
	logic                mul_q;
	logic                done_q;
	logic [1:0]          axis_q;
	logic [ABS_W-1:0]    absd_q;
	logic [KEY_W-1:0]    acc_q;

	logic [COORD_W-1:0]  v;
	logic [COORD_W-1:0]  lo;
	logic [COORD_W-1:0]  hi;
	logic [COORD_W+2:0]  twice;
	logic [COORD_W+2:0]  sum;
	logic [COORD_W+2:0]  diff;
	logic [COORD_W+2:0]  neg;
	logic [ABS_W-1:0]    absd;
	logic [2*ABS_W-1:0]  sq;

	always_comb begin
		unique case (axis_q)
			AXIS_X: begin
				v  = viewer.x;
				lo = cmd.box_min_x;
				hi = cmd.box_max_x;
			end
			AXIS_Y: begin
				v  = viewer.y;
				lo = cmd.box_min_y;
				hi = cmd.box_max_y;
			end
			default: begin
				v  = viewer.z;
				lo = cmd.box_min_z;
				hi = cmd.box_max_z;
			end
		endcase
	end

	// 2*viewer - (min+max), at most 131070 in magnitude
	assign twice = {{2{v[COORD_W-1]}}, v, 1'b0};
	assign sum   = {{3{lo[COORD_W-1]}}, lo} + {{3{hi[COORD_W-1]}}, hi};
	assign diff  = twice - sum;
	assign neg   = -diff;
	assign absd  = diff[COORD_W+2] ? neg[ABS_W-1:0] : diff[ABS_W-1:0];
	assign sq    = absd_q * absd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			mul_q  <= 1'b0;
			done_q <= 1'b0;
			axis_q <= AXIS_X;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				mul_q  <= 1'b0;
				axis_q <= AXIS_X;
			end else if (run_q) begin
				mul_q <= !mul_q;
				if (mul_q) begin
					if (axis_q == AXIS_Z) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
		end else if (run_q) begin
			if (mul_q) begin
				acc_q <= acc_q + KEY_W'(sq);
			end else begin
				absd_q <= absd;
			end
		end
	end

	assign done = done_q;
	assign key  = acc_q;

endmodule

`default_nettype wire

### hdl/nearest_k_entity_selector.sv
// Keeps up to capacity entity numbers closest to the viewer, ordered by arrival. A command
// word is taken when start is high and busy is low; exactly one result word follows with a
// one-cycle done strobe and cannot be held off. Clear, an unused operation and a read of a
// slot at or above the count answer in the cycle after start; a valid slot read passes
// through the read state first. An offer computes the key on the shared square-accumulate
// unit and appends while the list has room. When full it then sweeps the single-read-port
// entry memory for the farthest key and, only if the new key is smaller, shifts any later
// entries through the same port and appends; otherwise the offer is not kept.
// depends on nkes_pkg and nkes_key_unit
`default_nettype none

module nearest_k_entity_selector
	import nkes_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire cmd_t                   cmd,
	output logic                        done,
	output result_t                     result,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_KEY       = 4'd1;
	localparam logic [3:0] S_SCAN      = 4'd2;
	localparam logic [3:0] S_SCAN_END  = 4'd3;
	localparam logic [3:0] S_DECIDE    = 4'd4;
	localparam logic [3:0] S_SHIFT     = 4'd5;
	localparam logic [3:0] S_SHIFT_END = 4'd6;
	localparam logic [3:0] S_APPEND    = 4'd7;
	localparam logic [3:0] S_READ      = 4'd8;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_q;
	viewer_t           viewer_q;
	logic              done_q;
	result_t           result_q;
	cmd_t              cmd_q;
	logic              rd_vld_q;
	logic              sh_vld_q;
	logic [AW-1:0]     rd_idx_q;
	logic [AW-1:0]     sh_idx_q;
	logic [AW-1:0]     scan_addr_q;
	logic [AW-1:0]     sh_rd_q;
	logic [AW-1:0]     best_idx_q;
	logic [KEY_W-1:0]  best_key_q;
	logic [ID_W-1:0]   best_id_q;

	entry_t            mem [MAX_ENTRIES];
	entry_t            rd_data_q;
	logic [AW-1:0]     ra;
	logic              we;
	logic [AW-1:0]     wa;
	entry_t            wd;

	logic              key_go;
	logic              key_done;
	logic [KEY_W-1:0]  key;

	logic              accept;
	logic              full;
	logic [AW-1:0]     last;
	logic              slot_ok;
	logic              best_upd;
	entry_t            new_entry;

	nkes_key_unit u_key (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (key_go),
		.viewer (viewer_q),
		.cmd    (cmd_q),
		.done   (key_done),
		.key    (key)
	);

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign full      = (count_q >= cap_q) || (32'(count_q) >= MAX_ENTRIES);
	assign last      = AW'(count_q - 9'd1);
	assign slot_ok   = ({1'b0, cmd.slot} < count_q);
	assign new_entry = '{id: cmd_q.entity_id, key: key};
	// first entry always seeds the running maximum; ties keep the earlier one
	assign best_upd  = rd_vld_q && ((rd_idx_q == '0) || (rd_data_q.key > best_key_q));

	always_comb begin
		unique case (state_q)
			S_SCAN:  ra = scan_addr_q;
			S_SHIFT: ra = sh_rd_q;
			default: ra = AW'(cmd.slot);
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = new_entry;
		if ((state_q == S_KEY) && key_done && !full) begin
			we = 1'b1;
			wa = AW'(count_q);
		end else if (sh_vld_q) begin
			we = 1'b1;
			wa = sh_idx_q - AW'(1);
			wd = rd_data_q;
		end else if (state_q == S_APPEND) begin
			we = 1'b1;
			wa = last;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_q <= mem[ra];
	end

	assign key_go = accept && (cmd.operation == OP_OFFER);

	// control: state, count, config, strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cap_q    <= CAPACITY_RST;
			viewer_q <= '0;
			done_q   <= 1'b0;
			rd_vld_q <= 1'b0;
			sh_vld_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			rd_vld_q <= (state_q == S_SCAN);
			sh_vld_q <= (state_q == S_SHIFT);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CAPACITY: cap_q      <= cfg_data[CNT_W-1:0];
					CFG_VIEWER_X: viewer_q.x <= cfg_data;
					CFG_VIEWER_Y: viewer_q.y <= cfg_data;
					default:      viewer_q.z <= cfg_data;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd.operation)
							OP_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							OP_OFFER: state_q <= S_KEY;
							OP_READ: begin
								if (slot_ok) begin
									state_q <= S_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_KEY: begin
					if (key_done) begin
						if (!full) begin
							count_q <= count_q + 9'd1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (count_q == '0) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_addr_q == last) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (best_key_q > key) begin
						state_q <= (best_idx_q == last) ? S_APPEND : S_SHIFT;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SHIFT: begin
					if (sh_rd_q == last) begin
						state_q <= S_SHIFT_END;
					end
				end
				S_SHIFT_END: state_q <= S_APPEND;
				S_APPEND: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_READ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: command copy, scan and shift pointers, result word
	always_ff @(posedge clk) begin
		rd_idx_q <= scan_addr_q;
		sh_idx_q <= sh_rd_q;
		if (accept) begin
			cmd_q <= cmd;
		end
		if (best_upd) begin
			best_key_q <= rd_data_q.key;
			best_id_q  <= rd_data_q.id;
			best_idx_q <= rd_idx_q;
		end
		if (state_q == S_KEY) begin
			scan_addr_q <= '0;
		end else if (state_q == S_SCAN) begin
			scan_addr_q <= scan_addr_q + AW'(1);
		end
		if (state_q == S_DECIDE) begin
			sh_rd_q <= best_idx_q + AW'(1);
		end else if (state_q == S_SHIFT) begin
			sh_rd_q <= sh_rd_q + AW'(1);
		end

		unique case (state_q)
			S_IDLE: begin
				result_q <= '0;
				if (accept && (cmd.operation != OP_CLEAR)) begin
					result_q.entry_count <= count_q;
				end
			end
			S_KEY: begin
				result_q             <= '0;
				result_q.kept        <= !full;
				result_q.entry_count <= full ? count_q : count_q + 9'd1;
			end
			S_DECIDE: begin
				result_q             <= '0;
				result_q.entry_count <= count_q;
			end
			S_APPEND: begin
				result_q               <= '0;
				result_q.kept          <= 1'b1;
				result_q.evicted_valid <= 1'b1;
				result_q.evicted_id    <= best_id_q;
				result_q.entry_count   <= count_q;
			end
			S_READ: begin
				result_q             <= '0;
				result_q.entry_count <= count_q;
				result_q.slot_valid  <= 1'b1;
				result_q.slot_id     <= rd_data_q.id;
			end
			default: result_q <= result_q;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
